// ----- sv/utf16_to_utf8_transcoder_assert.svh -----
// Assertion macros shared by the transcoder checker.
// No dependencies; include by bare file name inside a module body.
`ifndef UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH
`define UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define U16U8_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define U16U8_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/u16u8_pkg.sv -----
// Shared types, constants and UTF-8 encode functions for the transcoder.
// No dependencies.
`timescale 1ns / 1ps

package u16u8_pkg;

  localparam logic [15:0] HI_FIRST = 16'hD800;
  localparam logic [15:0] HI_LAST  = 16'hDBFF;
  localparam logic [15:0] LO_FIRST = 16'hDC00;
  localparam logic [15:0] LO_LAST  = 16'hDFFF;

  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [20:0] MAX_1B    = 21'h0007F;
  localparam logic [20:0] MAX_2B    = 21'h007FF;
  localparam logic [20:0] MAX_3B    = 21'h0FFFF;

  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] CONT  = 8'h80;

  localparam logic [5:0] HI_TAG = 6'b110110;  // upper bits of a high surrogate

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One queued request: optional held surrogate (3 bytes), then optional code point.
  typedef struct packed {
    logic        has_held;
    logic [9:0]  held_bits;
    logic        has_cp;
    logic [20:0] cp;
    logic        text_done;
  } job_t;

  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] n;
    if (cp <= MAX_1B) n = 3'd1;
    else if (cp <= MAX_2B) n = 3'd2;
    else if (cp <= MAX_3B) n = 3'd3;
    else n = 3'd4;
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] pos);
    logic [2:0] n;
    logic [7:0] b;
    n = utf8_len(cp);
    b = CONT | {2'b00, cp[5:0]};
    case (n)
      3'd1: b = {1'b0, cp[6:0]};
      3'd2: begin
        if (pos == 2'd0) b = LEAD2 | {3'b000, cp[10:6]};
      end
      3'd3: begin
        case (pos)
          2'd0: b = LEAD3 | {4'b0000, cp[15:12]};
          2'd1: b = CONT | {2'b00, cp[11:6]};
          default: b = CONT | {2'b00, cp[5:0]};
        endcase
      end
      default: begin
        case (pos)
          2'd0: b = LEAD4 | {5'b00000, cp[20:18]};
          2'd1: b = CONT | {2'b00, cp[17:12]};
          2'd2: b = CONT | {2'b00, cp[11:6]};
          default: b = CONT | {2'b00, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

// ----- sv/u16u8_front.sv -----
// Front end: accepts code units, pairs surrogates, pushes encode requests.
// Depends on u16u8_pkg.
`timescale 1ns / 1ps

module u16u8_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_code_unit,
  input  logic               in_string_end,
  output logic               job_valid,
  output u16u8_pkg::job_t    job,
  input  logic               job_ready
);
  import u16u8_pkg::*;

  logic       held_valid_r, held_valid_nxt;
  logic [9:0] held_bits_r, held_bits_nxt;
  logic       accept, is_high, is_low, joined;

  assign in_ready = job_ready;
  assign accept   = in_valid & in_ready;
  assign is_high  = in_code_unit inside {[HI_FIRST:HI_LAST]};
  assign is_low   = in_code_unit inside {[LO_FIRST:LO_LAST]};
  assign joined   = held_valid_r & is_low;

  always_comb begin
    job            = '0;
    job.text_done  = in_string_end;
    held_valid_nxt = held_valid_r;
    held_bits_nxt  = held_bits_r;
    if (accept) begin
      held_valid_nxt = 1'b0;
      held_bits_nxt  = '0;
      if (joined) begin
        job.has_cp = 1'b1;
        job.cp     = SUPP_BASE + {1'b0, held_bits_r, in_code_unit[9:0]};
      end else begin
        job.has_held  = held_valid_r;
        job.held_bits = held_bits_r;
        if (is_high && !in_string_end) begin
          held_valid_nxt = 1'b1;
          held_bits_nxt  = in_code_unit[9:0];
        end else begin
          job.has_cp = 1'b1;
          job.cp     = {5'b00000, in_code_unit};
        end
      end
    end
  end

  // A held high surrogate with nothing else produces no request.
  assign job_valid = accept & (job.has_held | job.has_cp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_bits_r  <= '0;
    end else begin
      held_valid_r <= held_valid_nxt;
      held_bits_r  <= held_bits_nxt;
    end
  end

endmodule

// ----- sv/u16u8_queue.sv -----
// Small request queue between front end and byte emitter.
// Depends on u16u8_pkg.
`timescale 1ns / 1ps

module u16u8_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  u16u8_pkg::job_t push_job,
  output logic            pop_valid,
  input  logic            pop_ready,
  output u16u8_pkg::job_t pop_job
);
  import u16u8_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

// ----- sv/u16u8_back.sv -----
// Back end: walks one queued request byte by byte into the output register.
// Depends on u16u8_pkg.
`timescale 1ns / 1ps

module u16u8_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  output logic            job_ready,
  input  u16u8_pkg::job_t job,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_run_last,
  output logic            out_text_done
);
  import u16u8_pkg::*;

  localparam logic [2:0] HELD_BYTES = 3'd3;

  logic [2:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        run_last_r, run_last_nxt;
  logic        text_done_r, text_done_nxt;
  logic [2:0]  n_held, n_cp, total, cp_pos;
  logic        sel_held, last_byte, load;
  logic [20:0] held_cp;

  assign n_held    = job.has_held ? HELD_BYTES : 3'd0;
  assign n_cp      = job.has_cp ? utf8_len(job.cp) : 3'd0;
  assign total     = n_held + n_cp;
  assign sel_held  = idx_r < n_held;
  assign cp_pos    = idx_r - n_held;
  assign held_cp   = {5'b00000, HI_TAG, job.held_bits};
  assign last_byte = (idx_r == total - 3'd1);
  assign load      = job_valid & (~out_valid_r | out_ready);
  assign job_ready = load & last_byte;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    byte_nxt      = byte_r;
    run_last_nxt  = run_last_r;
    text_done_nxt = text_done_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      byte_nxt      = sel_held ? utf8_byte(held_cp, idx_r[1:0])
                               : utf8_byte(job.cp, cp_pos[1:0]);
      run_last_nxt  = last_byte;
      text_done_nxt = last_byte & job.text_done;
      idx_nxt       = last_byte ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    run_last_r  <= run_last_nxt;
    text_done_r <= text_done_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = byte_r;
  assign out_run_last  = run_last_r;
  assign out_text_done = text_done_r;

endmodule

// ----- sv/utf16_to_utf8_transcoder.sv -----
// UTF-16 to UTF-8 transcoder, top level. Each accepted code unit yields 0 to 6 UTF-8
// bytes, one byte per cycle while out_ready is high, through a registered output; a
// high surrogate that does not end the string is held and joined with the next unit
// (4 bytes) or emitted alone as 3 bytes. Units enter a 2-deep request queue at one per
// cycle; in_ready drops only while the queue is full. The sustained rate is set by the
// byte emitter, which pops a request only with its last byte; a unit causes 1 to 3 bytes
// for most text, 4 per surrogate pair over two units, and a surrogate that is held, none yet.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back.
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_code_unit,
  input  logic        in_string_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_text_done
);
  import u16u8_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_job, pop_job;

  u16u8_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_code_unit  (in_code_unit),
    .in_string_end (in_string_end),
    .job_valid     (push_valid),
    .job           (push_job),
    .job_ready     (push_ready)
  );

  u16u8_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  u16u8_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (pop_valid),
    .job_ready     (pop_ready),
    .job           (pop_job),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_text_done (out_text_done)
  );

endmodule

// ----- sv/u16u8_checker.sv -----
// Port-level checks on the transcoder output stream, bound to the top level.
// Depends on utf16_to_utf8_transcoder_assert.svh.
`timescale 1ns / 1ps

module u16u8_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_run_last,
  input logic        out_text_done
);
  `include "utf16_to_utf8_transcoder_assert.svh"

  // a stalled byte stays offered and unchanged
  `U16U8_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "out_valid dropped")
  `U16U8_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_byte), "out_byte changed")
  // end of string always closes the request's byte run
  `U16U8_ASSERT_NOW(a_done_last, clk, rst_n, out_valid && out_text_done, out_run_last, "text_done w/o run_last")
  // ASCII only comes from the current unit, so it ends the run
  `U16U8_ASSERT_NOW(a_ascii_last, clk, rst_n, out_valid && !out_byte[7], out_run_last, "ASCII not last")
  // a lead byte always has continuation bytes after it
  `U16U8_ASSERT_NOW(a_lead_not_last, clk, rst_n, out_valid && out_byte[7] && out_byte[6], !out_run_last, "lead byte ends run")

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_byte      (out_byte),
  .out_run_last  (out_run_last),
  .out_text_done (out_text_done)
);
